// ----- src/nearest_free_cell_search_defines.svh -----
// assertion macros for the nearest free cell search block
// no dependencies; taken in by the controller and the datapath
`ifndef NEAREST_FREE_CELL_SEARCH_DEFINES_SVH
`define NEAREST_FREE_CELL_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NFCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfcs assertion failed");
// next-cycle implication
`define NFCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfcs assertion failed");
`else
`define NFCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NFCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/nfcs_pkg.sv -----
// shared types and constants for the nearest free cell search block
// no dependencies
`default_nettype none

package nfcs_pkg;

  localparam int CELL_COUNT_DEF = 361;
  localparam int IDX_W          = 9;
  localparam int MARK_W         = 2;
  localparam int COORD_W        = 16;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int SQ_W           = 32;
  localparam int DIST_W         = SQ_W + 2;
  localparam int ENTRY_W        = MARK_W + 3 * COORD_W;

  localparam logic              OP_WRITE      = 1'b0;
  localparam logic              OP_QUERY      = 1'b1;
  localparam logic [MARK_W-1:0] MARK_EXCLUDED = 2'd1;
  // 1.0 squared for q8.8 coordinates, as a q18.16 squared distance
  localparam logic [DIST_W-1:0] UNIT_SQ       = 34'd65536;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } nfcs_state_t;

  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic clr_we;
    logic host_we;
    logic start;
    logic issue;
    logic load_out;
  } nfcs_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
  } nfcs_sts_t;

endpackage

`default_nettype wire

// ----- src/nearest_free_cell_search.sv -----
// nearest free cell search: a write is taken in idle and gives no result
// a query scans one cell per cycle, set by the single read port of the cell table;
// after the scan the distance pipeline drains and the result is registered once
// the output register is free; one item at a time: the next item after a query
// is taken only once its result has been loaded into the output register
// after reset a clearing pass zeroes every cell of the table with in_stall high
`default_nettype none

module nearest_free_cell_search #(
  parameter int CELL_COUNT = nfcs_pkg::CELL_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic        [nfcs_pkg::IDX_W-1:0]   in_cell_index,
  input  wire logic        [nfcs_pkg::MARK_W-1:0]  in_cell_mark,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_found,
  output logic             [nfcs_pkg::IDX_W-1:0]   out_nearest_index
);

  nfcs_pkg::nfcs_cmd_t cmd;
  nfcs_pkg::nfcs_sts_t sts;

  nfcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  nfcs_dp #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cell_index     (in_cell_index),
    .in_cell_mark      (in_cell_mark),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index)
  );

endmodule

`default_nettype wire

// ----- src/nfcs_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module nfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/nfcs_ctrl.sv -----
// controller state machine: clear pass, idle, scan, drain, result handoff
// depends on nfcs_pkg and nearest_free_cell_search_defines.svh
`default_nettype none
`include "nearest_free_cell_search_defines.svh"

module nfcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_opcode,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output nfcs_pkg::nfcs_cmd_t       cmd,
  input  wire nfcs_pkg::nfcs_sts_t  sts
);

  nfcs_pkg::nfcs_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfcs_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      nfcs_pkg::ST_CLEAR: begin
        cmd.clr_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = nfcs_pkg::ST_IDLE;
        end
      end
      nfcs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == nfcs_pkg::OP_QUERY) begin
            cmd.start   = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_nxt   = nfcs_pkg::ST_SCAN;
          end else begin
            cmd.host_we = 1'b1;
          end
        end
      end
      nfcs_pkg::ST_SCAN: begin
        cmd.issue   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = nfcs_pkg::ST_DRAIN;
        end
      end
      nfcs_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = nfcs_pkg::ST_RESULT;
        end
      end
      nfcs_pkg::ST_RESULT: begin
        // wait for the output slot to free up
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = nfcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nfcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != nfcs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `NFCS_ASSERT_NXT(a_query_starts_scan, clk, rst_n,
    in_valid && !in_stall && in_opcode == nfcs_pkg::OP_QUERY, state_r == nfcs_pkg::ST_SCAN)
  `NFCS_ASSERT_IMP(a_load_into_free_slot, clk, rst_n,
    cmd.load_out, !out_valid_r || !out_stall)

endmodule

`default_nettype wire

// ----- src/nfcs_dp.sv -----
// datapath: cell table, scan counter, distance pipeline, best tracker, result register
// depends on nfcs_pkg, nfcs_ram and nearest_free_cell_search_defines.svh
`default_nettype none
`include "nearest_free_cell_search_defines.svh"

module nfcs_dp #(
  parameter int CELL_COUNT = nfcs_pkg::CELL_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire nfcs_pkg::nfcs_cmd_t                 cmd,
  output nfcs_pkg::nfcs_sts_t                      sts,
  input  wire logic        [nfcs_pkg::IDX_W-1:0]   in_cell_index,
  input  wire logic        [nfcs_pkg::MARK_W-1:0]  in_cell_mark,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic signed [nfcs_pkg::COORD_W-1:0] in_coord_z,
  output logic                                     out_found,
  output logic             [nfcs_pkg::IDX_W-1:0]   out_nearest_index
);

  localparam int AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IW  = nfcs_pkg::IDX_W;
  localparam int CW  = nfcs_pkg::COORD_W;
  localparam int DW  = nfcs_pkg::DIFF_W;
  localparam int SW  = nfcs_pkg::SQ_W;
  localparam int TW  = nfcs_pkg::DIST_W;
  localparam int EW  = nfcs_pkg::ENTRY_W;
  localparam int MW  = nfcs_pkg::MARK_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);

  // scan / clear address counter
  logic [AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // cell table: {mark, z, y, x}
  logic          in_range;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  assign in_range  = (32'(in_cell_index) < 32'(CELL_COUNT));
  assign ram_we    = cmd.clr_we || (cmd.host_we && in_range);
  assign ram_waddr = cmd.clr_we ? cnt_r : AW'(in_cell_index);
  assign ram_wdata = cmd.clr_we ? '0 : {in_cell_mark, in_coord_z, in_coord_y, in_coord_x};

  nfcs_ram #(
    .WIDTH (EW),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // query point
  logic signed [CW-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
      pz_r <= in_coord_z;
    end
  end

  // pipeline valid bits
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // stage 1: ram data lines up with its index
  logic [AW-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r;
  end

  // stage 2: per-axis differences
  logic signed [CW-1:0] rd_x, rd_y, rd_z;
  logic        [MW-1:0] rd_mark;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic                 s2_elig_r;
  logic        [AW-1:0] s2_idx_r;

  assign rd_x    = ram_rdata[CW-1:0];
  assign rd_y    = ram_rdata[2*CW-1:CW];
  assign rd_z    = ram_rdata[3*CW-1:2*CW];
  assign rd_mark = ram_rdata[EW-1:3*CW];

  always_comb begin
    dx_nxt = {rd_x[CW-1], rd_x} - {px_r[CW-1], px_r};
    dy_nxt = {rd_y[CW-1], rd_y} - {py_r[CW-1], py_r};
    dz_nxt = {rd_z[CW-1], rd_z} - {pz_r[CW-1], pz_r};
  end

  always_ff @(posedge clk) begin
    s2_dx_r   <= dx_nxt;
    s2_dy_r   <= dy_nxt;
    s2_dz_r   <= dz_nxt;
    s2_elig_r <= (rd_mark != nfcs_pkg::MARK_EXCLUDED);
    s2_idx_r  <= s1_idx_r;
  end

  // stage 3: squares, each below 2^32
  logic signed [2*DW-1:0] sqx_full, sqy_full, sqz_full;
  logic        [SW-1:0]   s3_sqx_r, s3_sqy_r, s3_sqz_r;
  logic                   s3_elig_r;
  logic        [AW-1:0]   s3_idx_r;

  always_comb begin
    sqx_full = s2_dx_r * s2_dx_r;
    sqy_full = s2_dy_r * s2_dy_r;
    sqz_full = s2_dz_r * s2_dz_r;
  end

  always_ff @(posedge clk) begin
    s3_sqx_r  <= sqx_full[SW-1:0];
    s3_sqy_r  <= sqy_full[SW-1:0];
    s3_sqz_r  <= sqz_full[SW-1:0];
    s3_elig_r <= s2_elig_r;
    s3_idx_r  <= s2_idx_r;
  end

  // stage 4: squared distance
  logic [TW-1:0] s4_sum_r;
  logic          s4_elig_r;
  logic [AW-1:0] s4_idx_r;

  always_ff @(posedge clk) begin
    s4_sum_r  <= TW'(s3_sqx_r) + TW'(s3_sqy_r) + TW'(s3_sqz_r);
    s4_elig_r <= s3_elig_r;
    s4_idx_r  <= s3_idx_r;
  end

  // best tracker; strict compare keeps the lower index on a tie
  logic          have_r;
  logic [TW-1:0] best_r;
  logic [AW-1:0] best_idx_r;
  logic          take;

  assign take = s4_v_r && s4_elig_r && (!have_r || (s4_sum_r < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.start) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= s4_sum_r;
      best_idx_r <= s4_idx_r;
    end
  end

  // result register
  logic          found_nxt;
  logic          found_r;
  logic [IW-1:0] nearest_r;

  assign found_nxt = have_r && (best_r <= nfcs_pkg::UNIT_SQ);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r   <= found_nxt;
      nearest_r <= found_nxt ? IW'(best_idx_r) : '0;
    end
  end

  assign out_found         = found_r;
  assign out_nearest_index = nearest_r;

  assign sts.cnt_last  = (cnt_r == LAST_ADDR);
  assign sts.pipe_busy = s1_v_r || s2_v_r || s3_v_r || s4_v_r;

  `NFCS_ASSERT_NXT(a_start_drops_best, clk, rst_n, cmd.start, !have_r)
  `NFCS_ASSERT_IMP(a_best_never_grows, clk, rst_n,
    have_r && $past(have_r) && !$past(cmd.start), best_r <= $past(best_r))

endmodule

`default_nettype wire

// ----- bench/tb_nearest_free_cell_search.sv -----
// testbench for nearest_free_cell_search: directed and random cell writes and queries
// checked against a shadow cell table with an exhaustive nearest-cell search
// depends on nfcs_pkg and the nearest_free_cell_search top level
module tb_nearest_free_cell_search;
  timeunit 1ns;
  timeprecision 1ps;

  import nfcs_pkg::*;

  localparam int CELL_COUNT  = CELL_COUNT_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CALM_FROM   = 20000;
  localparam int CALM_TO     = 35000;
  localparam int HOLD_AT     = 6000;
  localparam int HOLD_LEN    = 3000;
  localparam int RAND_ITEMS  = 1200;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic              opcode;
    logic [IDX_W-1:0]  index;
    logic [MARK_W-1:0] mark;
    coord_t            x;
    coord_t            y;
    coord_t            z;
  } cell_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OP_WRITE;
  logic [IDX_W-1:0]  in_cell_index = '0;
  logic [MARK_W-1:0] in_cell_mark = '0;
  coord_t            in_coord_x = '0;
  coord_t            in_coord_y = '0;
  coord_t            in_coord_z = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_found;
  logic [IDX_W-1:0]  out_nearest_index;

  // shadow copy of the cell table
  coord_t            pos_x    [CELL_COUNT] = '{default: '0};
  coord_t            pos_y    [CELL_COUNT] = '{default: '0};
  coord_t            pos_z    [CELL_COUNT] = '{default: '0};
  logic [MARK_W-1:0] mark_tab [CELL_COUNT] = '{default: '0};

  cell_req_t req_q [$];
  cell_req_t placed_q [$];
  nearest_t  nearest_exp_q [$];
  cell_req_t cur_req;
  nearest_t  want;

  int  cycle = 0;
  int  park_left = 0;
  int  err_count = 0;
  wire calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  nearest_free_cell_search #(
    .CELL_COUNT(CELL_COUNT)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_cell_index     (in_cell_index),
    .in_cell_mark      (in_cell_mark),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic nearest_t nearest_cell(coord_t px, coord_t py, coord_t pz);
    nearest_t r;
    longint   best;
    longint   d;
    longint   dx;
    longint   dy;
    longint   dz;
    int       best_idx;
    bit       have;
    r        = '0;
    best     = 0;
    best_idx = 0;
    have     = 1'b0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      if (mark_tab[i] != MARK_EXCLUDED) begin
        dx = longint'(pos_x[i]) - longint'(px);
        dy = longint'(pos_y[i]) - longint'(py);
        dz = longint'(pos_z[i]) - longint'(pz);
        d  = dx * dx + dy * dy + dz * dz;
        // strict compare keeps the lower index on a tie
        if (!have || d < best) begin
          have     = 1'b1;
          best     = d;
          best_idx = i;
        end
      end
    end
    if (have && best <= longint'(UNIT_SQ)) begin
      r.found = 1'b1;
      r.idx   = best_idx[IDX_W-1:0];
    end
    return r;
  endfunction

  function automatic void track_transfer(cell_req_t r);
    if (r.opcode == OP_WRITE) begin
      if (r.index < CELL_COUNT) begin
        pos_x[r.index]    = r.x;
        pos_y[r.index]    = r.y;
        pos_z[r.index]    = r.z;
        mark_tab[r.index] = r.mark;
      end
    end else begin
      nearest_exp_q.push_back(nearest_cell(r.x, r.y, r.z));
    end
  endfunction

  function automatic void push_write(int idx, logic [MARK_W-1:0] mark,
                                     coord_t x, coord_t y, coord_t z);
    cell_req_t r;
    r.opcode = OP_WRITE;
    r.index  = idx[IDX_W-1:0];
    r.mark   = mark;
    r.x      = x;
    r.y      = y;
    r.z      = z;
    req_q.push_back(r);
    placed_q.push_back(r);
  endfunction

  function automatic void push_query(coord_t x, coord_t y, coord_t z);
    cell_req_t r;
    r.opcode = OP_QUERY;
    // index and mark mean nothing to a query, so fill them with noise
    r.index  = IDX_W'($urandom);
    r.mark   = MARK_W'($urandom);
    r.x      = x;
    r.y      = y;
    r.z      = z;
    req_q.push_back(r);
  endfunction

  function automatic coord_t jitter(coord_t c, int span);
    int off;
    off = $urandom_range(2 * span) - span;
    return c + COORD_W'(off);
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_transfer(cur_req);
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && !take_break()) begin
          cur_req = req_q.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= cur_req.opcode;
          in_cell_index <= cur_req.index;
          in_cell_mark  <= cur_req.mark;
          in_coord_x    <= cur_req.x;
          in_coord_y    <= cur_req.y;
          in_coord_z    <= cur_req.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold so the block backs up into its input
  always @(posedge clk) begin
    if (cycle == HOLD_AT) begin
      park_left <= HOLD_LEN;
    end else if (park_left != 0) begin
      park_left <= park_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (nearest_exp_q.size() == 0) begin
          $error("unexpected result: found %0d nearest_index %0d", out_found,
                 out_nearest_index);
          err_count++;
        end else begin
          want = nearest_exp_q.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_found);
            err_count++;
          end
          if (out_nearest_index !== want.idx) begin
            $error("nearest_index: expected %0d, actual %0d", want.idx,
                   out_nearest_index);
            err_count++;
          end
        end
      end
      out_stall <= (park_left != 0) || take_break();
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("tb_nearest_free_cell_search: FAIL");
      $finish;
    end
  end

  initial begin
    cell_req_t anchor;
    coord_t    hub_x [4];
    coord_t    hub_y [4];
    coord_t    hub_z [4];
    int        h;
    int        sel;
    int        span;

    // fresh table: every cell at the origin, all tie, lowest wins
    push_query(16'sd0, 16'sd0, 16'sd0);
    push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_query(16'sh8000, 16'sh8000, 16'sh8000);
    // excluded cell is skipped
    push_write(0, MARK_EXCLUDED, 16'sd0, 16'sd0, 16'sd0);
    push_query(16'sd0, 16'sd0, 16'sd0);
    // two cells at the same spot, query exactly 1.0 away
    push_write(5, 2'd0, 16'sd1000, 16'sd0, 16'sd0);
    push_write(7, 2'd2, 16'sd1000, 16'sd0, 16'sd0);
    push_query(16'sd1256, 16'sd0, 16'sd0);
    push_query(16'sd1257, 16'sd0, 16'sd0);
    push_query(16'sd1000, -16'sd256, 16'sd0);
    // top index at the most negative corner
    push_write(CELL_COUNT - 1, 2'd3, 16'sh8000, 16'sh8000, 16'sh8000);
    push_query(16'sh8000, 16'sh8000, 16'sh8000);
    // writes past the table end change nothing
    push_write(CELL_COUNT, 2'd0, 16'sh7fff, 16'sd0, 16'sh8000);
    push_write(511, 2'd0, 16'sh7fff, 16'sd0, 16'sh8000);
    push_query(16'sh7fff, 16'sd0, 16'sh8000);
    push_write(5, MARK_EXCLUDED, 16'sd1000, 16'sd0, 16'sd0);
    push_query(16'sd1000, 16'sd0, 16'sd0);
    push_write(2, 2'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);

    // exclude every cell, nothing can be found
    for (int k = 0; k < CELL_COUNT; k++) begin
      push_write(k, MARK_EXCLUDED, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom));
    end
    push_query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    anchor = placed_q[placed_q.size() - 1];
    push_query(anchor.x, anchor.y, anchor.z);

    for (int k = 0; k < 4; k++) begin
      hub_x[k] = coord_t'($urandom);
      hub_y[k] = coord_t'($urandom);
      hub_z[k] = coord_t'($urandom);
    end

    // mostly clustered cells with queries landing close to them
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(9) < 7) begin
          anchor = placed_q[$urandom_range(placed_q.size() - 1)];
          span   = $urandom_range(3) == 0 ? 0 : 160;
          push_query(jitter(anchor.x, span), jitter(anchor.y, span),
                     jitter(anchor.z, span));
        end else begin
          push_query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        end
      end else begin
        h   = $urandom_range(3);
        sel = $urandom_range(9);
        anchor.index = IDX_W'(($urandom_range(19) == 0) ? $urandom_range(511)
                                                        : $urandom_range(CELL_COUNT - 1));
        anchor.mark  = MARK_W'($urandom_range(3));
        if (sel < 7) begin
          push_write(anchor.index, anchor.mark, jitter(hub_x[h], 300),
                     jitter(hub_y[h], 300), jitter(hub_z[h], 300));
        end else if (sel == 7) begin
          // exact copy of an earlier spot to force distance ties
          anchor = placed_q[$urandom_range(placed_q.size() - 1)];
          push_write($urandom_range(CELL_COUNT - 1), MARK_W'($urandom_range(3)),
                     anchor.x, anchor.y, anchor.z);
        end else begin
          push_write(anchor.index, anchor.mark, coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom));
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (nearest_exp_q.size() != 0) @(posedge clk);
    repeat (CELL_COUNT + 40) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_nearest_free_cell_search: PASS");
    end else begin
      $display("tb_nearest_free_cell_search: FAIL");
    end
    $finish;
  end

endmodule

// ----- nearest_free_cell_search.f -----
+incdir+src
src/nfcs_pkg.sv
src/nfcs_ram.sv
src/nfcs_ctrl.sv
src/nfcs_dp.sv
src/nearest_free_cell_search.sv
bench/tb_nearest_free_cell_search.sv
